/* hw/rtl/ffba_pkg.sv */
// Shared constants, types and codes for the first-fit bin allocator.
`default_nettype none

package ffba_pkg;

   // Bin count and size width.
   localparam int NUM_BINS  = 64;
   localparam int SIZE_W    = 16;

   // Winner tree geometry: leaves sit at nodes LEAF_BASE .. LEAF_BASE+NUM_BINS-1.
   localparam int LEVELS    = $clog2(NUM_BINS);
   localparam int NODE_W    = LEVELS + 1;
   localparam int NODES     = 2 ** NODE_W;
   localparam int LEAF_BASE = 2 ** LEVELS;
   localparam int LVL_W     = $clog2(LEVELS + 1);

   // Result packing.
   localparam int BIN_OUT_W = 6;
   localparam int STATUS_W  = 2;
   localparam int RSP_W     = BIN_OUT_W + STATUS_W + SIZE_W;

   localparam logic [SIZE_W-1:0] CAP_RESET = {SIZE_W{1'b1}};

   typedef logic [SIZE_W-1:0] size_type;
   typedef logic [NODE_W-1:0] node_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_PLACED    = 2'd0,
      STATUS_TOO_LARGE = 2'd1,
      STATUS_NO_ROOM   = 2'd2
   } status_type;

   // Access bundle from the sequencer to the tree store.
   typedef struct packed {
      logic     rd_en;
      node_type rd_addr_a;
      node_type rd_addr_b;
      logic     wr_en;
      node_type wr_addr;
      size_type wr_data;
      logic     clear;
      size_type fill_data;
   } tree_req_type;

endpackage

`default_nettype wire

/* hw/rtl/ffba_tree_mem.sv */
// Winner tree store: two read ports, one write port, valid bits and refill value.
`default_nettype none

module ffba_tree_mem (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire ffba_pkg::tree_req_type tree_req,
   output logic [ffba_pkg::SIZE_W-1:0] rd_data_a,
   output logic [ffba_pkg::SIZE_W-1:0] rd_data_b
);

   localparam logic [ffba_pkg::NODE_W:0] PAD_START =
      (ffba_pkg::NODE_W + 1)'(ffba_pkg::LEAF_BASE + ffba_pkg::NUM_BINS);

   ffba_pkg::size_type           mem [ffba_pkg::NODES];
   logic [ffba_pkg::NODES-1:0]   valid_ff;
   ffba_pkg::size_type           fill_ff;
   ffba_pkg::size_type           raw_a_ff;
   ffba_pkg::size_type           raw_b_ff;
   logic                         hit_a_ff;
   logic                         hit_b_ff;
   logic                         pad_a_ff;
   logic                         pad_b_ff;
   logic                         hit_a_in;
   logic                         hit_b_in;
   logic                         pad_a_in;
   logic                         pad_b_in;

   // A node cleared in this cycle reads as the new fill value.
   always_comb begin
      hit_a_in = valid_ff[tree_req.rd_addr_a] & ~tree_req.clear;
      hit_b_in = valid_ff[tree_req.rd_addr_b] & ~tree_req.clear;
      pad_a_in = {1'b0, tree_req.rd_addr_a} >= PAD_START;
      pad_b_in = {1'b0, tree_req.rd_addr_b} >= PAD_START;
   end

   // Write port and registered read ports.
   always_ff @(posedge clock) begin
      if (tree_req.wr_en) begin
         mem[tree_req.wr_addr] <= tree_req.wr_data;
      end
      if (tree_req.rd_en) begin
         raw_a_ff <= mem[tree_req.rd_addr_a];
         raw_b_ff <= mem[tree_req.rd_addr_b];
         hit_a_ff <= hit_a_in;
         hit_b_ff <= hit_b_in;
         pad_a_ff <= pad_a_in;
         pad_b_ff <= pad_b_in;
      end
   end

   // Valid bits and refill value.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         fill_ff  <= ffba_pkg::CAP_RESET;
      end else begin
         if (tree_req.clear) begin
            valid_ff <= '0;
            fill_ff  <= tree_req.fill_data;
         end
         if (tree_req.wr_en) begin
            valid_ff[tree_req.wr_addr] <= 1'b1;
         end
      end
   end

   // Padding leaves hold no space; unwritten nodes hold the fill value.
   always_comb begin
      rd_data_a = pad_a_ff ? '0 : (hit_a_ff ? raw_a_ff : fill_ff);
      rd_data_b = pad_b_ff ? '0 : (hit_b_ff ? raw_b_ff : fill_ff);
   end

endmodule

`default_nettype wire

/* hw/rtl/first_fit_bin_allocator.sv */
// Top level of the first-fit bin allocator: request sequencer and result register.
`default_nettype none

// Places each request's object in the lowest-numbered of 64 bins whose free space is at
// least its size, and returns the bin, a status and the space left. Free space lives in a
// max winner tree held in one synchronous memory (two read ports, one write port); a
// placed object goes through the root read, the root check, one step per level on the way
// down (6 levels), one write per level on the way back up (7 writes) and the load of the
// result register before the next acceptance. A too-large object goes straight to that
// load, and an object that finds no room stops after the root check. Each can wait at the
// load while an earlier result still waits unaccepted in the output register. A restart flag
// refills the tree at once through per-node valid bits, so there is no clearing pass. The
// capacity register takes effect at the next restart; the too-large test uses its current
// value. A finished result waits in the output register while the next request is taken.
module first_fit_bin_allocator (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // [15:0] item_size
   input  wire logic        req_tuser,   // [0] restart
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // [5:0] bin_index, [7:6] status, [23:8] space_left
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROOT,
      ST_DESC,
      ST_ASC,
      ST_DONE
   } state_type;

   localparam int LV = ffba_pkg::LEVELS;
   localparam int NW = ffba_pkg::NODE_W;

   // Control registers.
   state_type                  state_ff, state_in;
   ffba_pkg::size_type         cap_ff, cap_in;
   logic                       rsp_tvalid_ff, rsp_tvalid_in;
   logic [ffba_pkg::LVL_W-1:0] level_ff, level_in;

   // Payload registers.
   ffba_pkg::size_type         size_ff, size_in;
   ffba_pkg::node_type         node_ff, node_in;
   ffba_pkg::node_type         wr_node_ff, wr_node_in;
   ffba_pkg::size_type         wr_val_ff, wr_val_in;
   ffba_pkg::size_type         sib_ff [LV];
   ffba_pkg::size_type         sib_in [LV];
   logic [ffba_pkg::BIN_OUT_W-1:0] res_bin_ff, res_bin_in;
   ffba_pkg::status_type       res_status_ff, res_status_in;
   ffba_pkg::size_type         res_space_ff, res_space_in;
   logic [ffba_pkg::RSP_W-1:0] rsp_tdata_ff, rsp_tdata_in;

   ffba_pkg::tree_req_type     tree_req;
   ffba_pkg::size_type         rd_data_a;
   ffba_pkg::size_type         rd_data_b;

   logic                       req_accept;
   logic                       rsp_free;
   logic                       left_fits;
   ffba_pkg::node_type         child;
   ffba_pkg::size_type         chosen;
   ffba_pkg::size_type         sibling;
   ffba_pkg::size_type         up_val;
   logic                       at_leaf;

   ffba_tree_mem u_tree_mem (
      .clock     (clock),
      .reset     (reset),
      .tree_req  (tree_req),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid & req_tready;
   assign rsp_free   = ~rsp_tvalid_ff | rsp_tready;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // Descent step: take the left child when it fits, else the right one.
   always_comb begin
      left_fits = (rd_data_a >= size_ff);
      child     = {node_ff[NW-2:0], ~left_fits};
      chosen    = left_fits ? rd_data_a : rd_data_b;
      sibling   = left_fits ? rd_data_b : rd_data_a;
      at_leaf   = (level_ff == ffba_pkg::LVL_W'(LV - 1));
      up_val    = (wr_val_ff >= sib_ff[0]) ? wr_val_ff : sib_ff[0];
   end

   // Sequencer next state and tree accesses.
   always_comb begin
      state_in      = state_ff;
      cap_in        = csr_wr_en ? csr_wr_data : cap_ff;
      rsp_tvalid_in = rsp_tvalid_ff & ~rsp_tready;
      level_in      = level_ff;
      size_in       = size_ff;
      node_in       = node_ff;
      wr_node_in    = wr_node_ff;
      wr_val_in     = wr_val_ff;
      res_bin_in    = res_bin_ff;
      res_status_in = res_status_ff;
      res_space_in  = res_space_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      for (int i = 0; i < LV; i++) begin
         sib_in[i] = sib_ff[i];
      end

      tree_req           = '0;
      tree_req.clear     = req_accept & req_tuser;
      tree_req.fill_data = cap_ff;

      unique case (state_ff)
         ST_IDLE: begin
            // Take a request and read the root, unless it is too large.
            if (req_accept) begin
               size_in = req_tdata;
               if (req_tdata > cap_ff) begin
                  res_status_in = ffba_pkg::STATUS_TOO_LARGE;
                  res_bin_in    = '0;
                  res_space_in  = '0;
                  state_in      = ST_DONE;
               end else begin
                  tree_req.rd_en     = 1'b1;
                  tree_req.rd_addr_a = NW'(1);
                  tree_req.rd_addr_b = NW'(1);
                  state_in           = ST_ROOT;
               end
            end
         end
         ST_ROOT: begin
            // Root holds the largest free space: drop the request if it is short.
            if (rd_data_a < size_ff) begin
               res_status_in = ffba_pkg::STATUS_NO_ROOM;
               res_bin_in    = '0;
               res_space_in  = '0;
               state_in      = ST_DONE;
            end else begin
               node_in            = NW'(1);
               level_in           = '0;
               tree_req.rd_en     = 1'b1;
               tree_req.rd_addr_a = NW'(2);
               tree_req.rd_addr_b = NW'(3);
               state_in           = ST_DESC;
            end
         end
         ST_DESC: begin
            // Push the sibling for the way back up.
            sib_in[0] = sibling;
            for (int i = 1; i < LV; i++) begin
               sib_in[i] = sib_ff[i-1];
            end
            if (at_leaf) begin
               if (chosen >= size_ff) begin
                  wr_node_in   = child;
                  wr_val_in    = chosen - size_ff;
                  res_space_in = chosen - size_ff;
                  res_bin_in   = ffba_pkg::BIN_OUT_W'(child[LV-1:0]);
                  state_in     = ST_ASC;
               end else begin
                  res_status_in = ffba_pkg::STATUS_NO_ROOM;
                  res_bin_in    = '0;
                  res_space_in  = '0;
                  state_in      = ST_DONE;
               end
            end else begin
               node_in            = child;
               level_in           = level_ff + 1'b1;
               tree_req.rd_en     = 1'b1;
               tree_req.rd_addr_a = {child[NW-2:0], 1'b0};
               tree_req.rd_addr_b = {child[NW-2:0], 1'b1};
            end
         end
         ST_ASC: begin
            // Write the node, then rebuild its parent from the popped sibling.
            tree_req.wr_en   = 1'b1;
            tree_req.wr_addr = wr_node_ff;
            tree_req.wr_data = wr_val_ff;
            if (wr_node_ff == NW'(1)) begin
               res_status_in = ffba_pkg::STATUS_PLACED;
               state_in      = ST_DONE;
            end else begin
               wr_node_in = wr_node_ff >> 1;
               wr_val_in  = up_val;
               for (int i = 0; i < LV - 1; i++) begin
                  sib_in[i] = sib_ff[i+1];
               end
            end
         end
         ST_DONE: begin
            // Load the result register once it is free.
            if (rsp_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {res_space_ff, res_status_ff, res_bin_ff};
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state and the result handshake.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cap_ff        <= ffba_pkg::CAP_RESET;
         rsp_tvalid_ff <= 1'b0;
         level_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         cap_ff        <= cap_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         level_ff      <= level_in;
      end
   end

   // Advance the payload registers.
   always_ff @(posedge clock) begin
      size_ff       <= size_in;
      node_ff       <= node_in;
      wr_node_ff    <= wr_node_in;
      wr_val_ff     <= wr_val_in;
      res_bin_ff    <= res_bin_in;
      res_status_ff <= res_status_in;
      res_space_ff  <= res_space_in;
      rsp_tdata_ff  <= rsp_tdata_in;
      for (int i = 0; i < LV; i++) begin
         sib_ff[i] <= sib_in[i];
      end
   end

   // A parent on the way up never holds less than the child below it.
   a_asc_max_grows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ASC && wr_node_ff != NW'(1)) |=> (wr_val_ff >= $past(wr_val_ff)))
      else $error("tree ascent lowered a node value");

   // Tree writes happen only on the way up and never to the unused node.
   a_write_in_asc: assert property (@(posedge clock) disable iff (reset)
      tree_req.wr_en |-> (state_ff == ST_ASC && tree_req.wr_addr != '0))
      else $error("tree write outside ascent");

   // An oversized request goes straight to the result with the too-large status.
   a_too_large: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_tdata > cap_ff) |=>
         (state_ff == ST_DONE && res_status_ff == ffba_pkg::STATUS_TOO_LARGE))
      else $error("too-large request not reported");

endmodule

`default_nettype wire

/* sim/first_fit_bin_allocator_checker.sv */
`timescale 1ns / 1ps
// Result checker for the first-fit bin allocator: predicts each request's result and compares.
module first_fit_bin_allocator_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [15:0] req_tdata,   // [15:0] item_size
   input  wire logic        req_tuser,   // [0] restart
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [23:0] rsp_tdata,   // [5:0] bin_index, [7:6] status, [23:8] space_left
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data,
   output int               mismatch_count,
   output int               pending_count,
   output int               placed_count,
   output int               too_large_count,
   output int               no_room_count
);

   typedef struct packed {
      logic [ffba_pkg::BIN_OUT_W-1:0] bin;
      ffba_pkg::status_type           status;
      ffba_pkg::size_type             space_left;
   } placement_type;

   // Own copy of the capacity register and of every bin's free space.
   ffba_pkg::size_type capacity;
   ffba_pkg::size_type bin_space [ffba_pkg::NUM_BINS];
   placement_type      placements_due [$];

   // Refill every bin to the current capacity.
   function automatic void refill_bins();
      for (int i = 0; i < ffba_pkg::NUM_BINS; i++)
         bin_space[i] = capacity;
   endfunction

   // Place one object first-fit and return the result it should produce.
   function automatic placement_type place_object(input ffba_pkg::size_type size,
                                                  input logic restart);
      placement_type r;
      int            slot;
      if (restart)
         refill_bins();
      r.bin        = '0;
      r.status     = ffba_pkg::STATUS_PLACED;
      r.space_left = '0;
      if (size > capacity) begin
         r.status = ffba_pkg::STATUS_TOO_LARGE;
         return r;
      end
      slot = -1;
      for (int i = 0; i < ffba_pkg::NUM_BINS && slot < 0; i++)
         if (bin_space[i] >= size)
            slot = i;
      if (slot < 0) begin
         r.status = ffba_pkg::STATUS_NO_ROOM;
         return r;
      end
      bin_space[slot] = bin_space[slot] - size;
      r.bin           = slot[ffba_pkg::BIN_OUT_W-1:0];
      r.space_left    = bin_space[slot];
      return r;
   endfunction

   // Count a failure; print only the first 10.
   task automatic report_mismatch(input string what, input placement_type want,
                                  input placement_type got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t %s: expected bin %0d status %0d space %0d, %s %0d %s %0d %s %0d",
                  $realtime, what, want.bin, want.status, want.space_left,
                  "got bin", got.bin, "status", got.status, "space", got.space_left);
   endtask

   // Track the register, predict on each request, compare on each result.
   always @(posedge clock) begin : monitor
      placement_type want;
      placement_type got;
      if (reset) begin
         capacity = ffba_pkg::CAP_RESET;
         refill_bins();
         placements_due.delete();
         mismatch_count  = 0;
         pending_count   = 0;
         placed_count    = 0;
         too_large_count = 0;
         no_room_count   = 0;
      end else begin
         if (req_tvalid && req_tready)
            placements_due.push_back(place_object(req_tdata, req_tuser));
         if (csr_wr_en)
            capacity = csr_wr_data;
         if (rsp_tvalid && rsp_tready) begin
            got.bin        = rsp_tdata[5:0];
            got.status     = ffba_pkg::status_type'(rsp_tdata[7:6]);
            got.space_left = rsp_tdata[23:8];
            if (placements_due.size() == 0) begin
               want = '0;
               report_mismatch("result with no request outstanding", want, got);
            end else begin
               want = placements_due.pop_front();
               if (got.bin !== want.bin || got.status !== want.status ||
                   got.space_left !== want.space_left)
                  report_mismatch("result mismatch", want, got);
               case (want.status)
                  ffba_pkg::STATUS_PLACED:    placed_count++;
                  ffba_pkg::STATUS_TOO_LARGE: too_large_count++;
                  default:                    no_room_count++;
               endcase
            end
         end
         pending_count = placements_due.size();
      end
   end

endmodule

/* sim/first_fit_bin_allocator_tb.sv */
`timescale 1ns / 1ps
// Testbench top for the first-fit bin allocator: clock, reset, stimulus and verdict.
module first_fit_bin_allocator_tb;

   localparam int SEGMENTS     = 9;
   localparam int SEG_REQUESTS = 215;
   localparam int DRAIN_CYCLES = 24;
   localparam int STALL_LIMIT  = 3000;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata   = '0;   // [15:0] item_size
   logic        req_tuser   = 1'b0; // [0] restart
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [23:0] rsp_tdata;          // [5:0] bin_index, [7:6] status, [23:8] space_left
   logic        csr_wr_en   = 1'b0;
   logic [15:0] csr_wr_data = '0;

   int mismatch_count;
   int pending_count;
   int placed_count;
   int too_large_count;
   int no_room_count;

   int send_idle_pct = 37;
   int recv_idle_pct = 46;
   int cap_setting   = 65535;
   int cap_writes    = 0;
   int stall_cycles  = 0;

   first_fit_bin_allocator dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   first_fit_bin_allocator_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .mismatch_count  (mismatch_count),
      .pending_count   (pending_count),
      .placed_count    (placed_count),
      .too_large_count (too_large_count),
      .no_room_count   (no_room_count)
   );

   // 12 ns clock.
   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // Stall the result side at random.
   always @(negedge clock)
      rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

   // End the run if nothing moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("first_fit_bin_allocator regression: fail");
            $finish;
         end
      end
   end

   // Offer one request, with a random gap first, and hold it until taken.
   task automatic send_object(input int size, input logic restart);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= size[15:0];
      req_tuser  <= restart;
      do
         @(posedge clock);
      while (!req_tready);
      @(negedge clock);
   endtask

   // Drop the request line and let every outstanding result drain.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_count != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Write the capacity register for one cycle.
   task automatic write_capacity(input int value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value[15:0];
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      cap_setting = value;
      cap_writes++;
   endtask

   // Pick an object size weighted towards sizes that fill bins under this capacity.
   function automatic int pick_size(input int cap);
      int r;
      r = $urandom_range(0, 99);
      if (r < 5)
         return 0;
      if (r < 10)
         return cap;
      if (r < 15)
         return (cap < 65535) ? $urandom_range(cap + 1, 65535) : $urandom_range(0, 65535);
      if (r < 20)
         return $urandom_range(0, 65535);
      if (r < 50)
         return $urandom_range(0, cap / 16);
      return $urandom_range(0, cap);
   endfunction

   // Capacity for each random segment, extremes included.
   function automatic int segment_capacity(input int seg);
      case (seg)
         0:       return 65535;
         1:       return 1;
         2:       return 40;
         3:       return 0;
         4:       return 1000;
         5:       return $urandom_range(1, 65535);
         6:       return 7;
         7:       return $urandom_range(2, 300);
         default: return 65535;
      endcase
   endfunction

   initial begin
      int seg;
      int n;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: extremes of size at the reset capacity, zero size, restart.
      send_object(0, 1'b0);
      send_object(16'hFFFF, 1'b0);
      send_object(1, 1'b0);
      send_object(16'hFFFF, 1'b0);
      send_object(0, 1'b0);
      send_object(16'h8000, 1'b1);
      send_object(16'h8000, 1'b0);
      send_object(16'h7FFF, 1'b0);
      send_object(16'h5555, 1'b0);
      send_object(16'hAAAA, 1'b0);

      // Directed: smaller capacity without restart, then too large with restart.
      settle();
      write_capacity(100);
      send_object(101, 1'b0);
      send_object(100, 1'b0);
      send_object(16'hFFFF, 1'b1);
      send_object(50, 1'b0);
      send_object(60, 1'b0);

      // Directed: zero capacity admits only empty objects.
      settle();
      write_capacity(0);
      send_object(0, 1'b1);
      send_object(1, 1'b0);

      // Random segments: restart on entry and at random after, SEG_REQUESTS requests each.
      for (seg = 0; seg < SEGMENTS; seg++) begin
         if (seg == 3) begin
            send_idle_pct = 46;
            recv_idle_pct = 37;
         end else if (seg == 6) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         settle();
         write_capacity(segment_capacity(seg));
         for (n = 0; n < SEG_REQUESTS; n++)
            send_object(pick_size(cap_setting), n == 0 || $urandom_range(0, 79) == 0);
      end

      settle();
      $display("Checked %0d results over %0d capacity settings:",
               placed_count + too_large_count + no_room_count, cap_writes + 1);
      $display("%0d placed, %0d too large, %0d no room.",
               placed_count, too_large_count, no_room_count);
      $display("Result mismatches: %0d", mismatch_count);
      if (mismatch_count == 0)
         $display("first_fit_bin_allocator regression: pass");
      else
         $display("first_fit_bin_allocator regression: fail");
      $finish;
   end

endmodule
